/* src/pgm_pkg.sv */
package pgm_pkg;

	localparam int GRID_MAX  = 1024;
	localparam int FRAC_BITS = 16;
	localparam int SIZE_W    = 24;
	localparam int GRID_W    = 11;
	localparam int POS_W     = 25;
	localparam int UV_W      = 17;
	localparam int IDX_W     = 21;
	localparam int DIV_STEPS = SIZE_W;
	localparam int NUM_W     = SIZE_W + GRID_W;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLANE_WIDTH  = 3'd0,
		REG_PLANE_HEIGHT = 3'd1,
		REG_GRID_COLS    = 3'd2,
		REG_GRID_ROWS    = 3'd3,
		REG_PLANE_DIR    = 3'd4,
		REG_UV_ENABLE    = 3'd5,
		REG_NORMAL_EN    = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		AXIS_NONE = 2'd0,
		AXIS_X    = 2'd1,
		AXIS_Y    = 2'd2,
		AXIS_Z    = 2'd3
	} axis_t;

	localparam logic [1:0] DIR_X = 2'd0;
	localparam logic [1:0] DIR_Y = 2'd1;
	localparam logic [1:0] DIR_Z = 2'd2;

	typedef struct packed {
		logic             quad_valid;
		logic [IDX_W-1:0] corner_a;
	} side_t;

	function automatic logic [GRID_W-1:0] clamp_grid(input logic [GRID_W-1:0] n);
		logic [GRID_W-1:0] r;
		r = n;
		if (n == '0)
			r = GRID_W'(1);
		else if (n > GRID_W'(GRID_MAX))
			r = GRID_W'(GRID_MAX);
		return r;
	endfunction

endpackage

/* src/pgm_div.sv */
module pgm_div (
	input  logic                             clk,
	input  logic                             en,
	input  logic [pgm_pkg::NUM_W-1:0]        num,
	input  logic [pgm_pkg::GRID_W-1:0]       den,
	output logic [pgm_pkg::DIV_STEPS-1:0]    quo
);

	localparam int S = pgm_pkg::DIV_STEPS;
	localparam int G = pgm_pkg::GRID_W;

	logic [G-1:0] rem_s [S];
	logic [S-1:0] low_s [S];
	logic [S-1:0] quo_s [S];
	logic [G-1:0] den_s [S];

	logic [G-1:0] rem_n [S];
	logic [S-1:0] low_n [S];
	logic [S-1:0] quo_n [S];
	logic [G-1:0] den_n [S];

	// Each stage retires one quotient bit with a narrow compare and subtract.
	// The dividend is below den * 2^S, so its top bits start the remainder.
	always_comb begin
		logic [G-1:0] r_in;
		logic [S-1:0] l_in;
		logic [S-1:0] q_in;
		logic [G-1:0] d_in;
		logic [G:0]   t;
		logic         ge;
		for (int k = 0; k < S; k++) begin
			if (k == 0) begin
				r_in = num[pgm_pkg::NUM_W-1:S];
				l_in = num[S-1:0];
				q_in = '0;
				d_in = den;
			end else begin
				r_in = rem_s[k-1];
				l_in = low_s[k-1];
				q_in = quo_s[k-1];
				d_in = den_s[k-1];
			end
			t  = {r_in, l_in[S-1]};
			ge = (t >= {1'b0, d_in});
			rem_n[k] = ge ? G'(t - {1'b0, d_in}) : t[G-1:0];
			low_n[k] = {l_in[S-2:0], 1'b0};
			quo_n[k] = {q_in[S-2:0], ge};
			den_n[k] = d_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < S; k++) begin
				rem_s[k] <= rem_n[k];
				low_s[k] <= low_n[k];
				quo_s[k] <= quo_n[k];
				den_s[k] <= den_n[k];
			end
		end
	end

	assign quo = quo_s[S-1];

endmodule

/* src/plane_grid_mesh_generator_top.sv */
// Plane grid vertex generator. Each transaction on the input channel carries one
// (row, column) grid point and produces exactly one vertex transaction, in order.
// A new point is taken every cycle while the output side keeps up. Each point
// passes the product stage, the four long-division pipelines (x, y, u, v), one
// quotient bit per stage over 24 stages, and the output register. The whole
// pipeline holds when a finished vertex is not taken. Configuration registers are
// written through the cfg channel, which is always ready, and must only be changed
// while no vertex is in flight.
module plane_grid_mesh_generator_top (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pgm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pgm_pkg::SIZE_W-1:0]       cfg_data,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [pgm_pkg::GRID_W-1:0]       grid_row,
	input  logic [pgm_pkg::GRID_W-1:0]       grid_col,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [pgm_pkg::POS_W-1:0] pos_x,
	output logic signed [pgm_pkg::POS_W-1:0] pos_y,
	output logic signed [pgm_pkg::POS_W-1:0] pos_z,
	output logic [pgm_pkg::UV_W-1:0]         tex_u,
	output logic [pgm_pkg::UV_W-1:0]         tex_v,
	output logic [1:0]                       normal_axis,
	output logic                             quad_valid,
	output logic [pgm_pkg::IDX_W-1:0]        corner_a,
	output logic [pgm_pkg::IDX_W-1:0]        corner_b,
	output logic [pgm_pkg::IDX_W-1:0]        corner_c,
	output logic [pgm_pkg::IDX_W-1:0]        corner_d
);

	localparam int S  = pgm_pkg::DIV_STEPS;
	localparam int G  = pgm_pkg::GRID_W;
	localparam int N  = pgm_pkg::NUM_W;
	localparam int SW = pgm_pkg::SIZE_W;
	localparam int PW = pgm_pkg::POS_W;
	localparam int IW = pgm_pkg::IDX_W;

	logic [SW-1:0] width_q, height_q;
	logic [G-1:0]  cols_q, rows_q;
	logic [1:0]    dir_q;
	logic          uv_en_q, nrm_en_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SW'(65536);
			height_q <= SW'(65536);
			cols_q   <= G'(1);
			rows_q   <= G'(1);
			dir_q    <= pgm_pkg::DIR_Z;
			uv_en_q  <= 1'b1;
			nrm_en_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (pgm_pkg::reg_idx_t'(cfg_index))
				pgm_pkg::REG_PLANE_WIDTH:  width_q  <= cfg_data;
				pgm_pkg::REG_PLANE_HEIGHT: height_q <= cfg_data;
				pgm_pkg::REG_GRID_COLS:    cols_q   <= cfg_data[G-1:0];
				pgm_pkg::REG_GRID_ROWS:    rows_q   <= cfg_data[G-1:0];
				pgm_pkg::REG_PLANE_DIR:    dir_q    <= cfg_data[1:0];
				pgm_pkg::REG_UV_ENABLE:    uv_en_q  <= cfg_data[0];
				pgm_pkg::REG_NORMAL_EN:    nrm_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [G-1:0] cols_c, rows_c, row_c, col_c;
	assign cols_c = pgm_pkg::clamp_grid(cols_q);
	assign rows_c = pgm_pkg::clamp_grid(rows_q);
	assign row_c  = (grid_row > rows_c) ? rows_c : grid_row;
	assign col_c  = (grid_col > cols_c) ? cols_c : grid_col;

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: clamped indices and the three products.
	logic          vld_s1;
	logic [N-1:0]  prod_x_s1, prod_y_s1;
	logic [IW-1:0] base_s1;
	logic [G-1:0]  row_s1, col_s1, cols_s1, rows_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_s1 <= N'(width_q) * N'(col_c);
			prod_y_s1 <= N'(height_q) * N'(row_c);
			base_s1   <= IW'(row_c) * (IW'(cols_c) + IW'(1));
			row_s1    <= row_c;
			col_s1    <= col_c;
			cols_s1   <= cols_c;
			rows_s1   <= rows_c;
		end
	end

	// Division stages; the corner data travels alongside.
	logic [S-1:0] qx, qy, qu, qv;

	pgm_div u_div_x (.clk(clk), .en(adv), .num(prod_x_s1), .den(cols_s1), .quo(qx));
	pgm_div u_div_y (.clk(clk), .en(adv), .num(prod_y_s1), .den(rows_s1), .quo(qy));
	pgm_div u_div_u (.clk(clk), .en(adv),
		.num(N'({col_s1, pgm_pkg::FRAC_BITS'(0)})), .den(cols_s1), .quo(qu));
	pgm_div u_div_v (.clk(clk), .en(adv),
		.num(N'({row_s1, pgm_pkg::FRAC_BITS'(0)})), .den(rows_s1), .quo(qv));

	logic           vld_s [S];
	pgm_pkg::side_t side_s [S];
	pgm_pkg::side_t side_in;

	assign side_in.quad_valid = (row_s1 < rows_s1) && (col_s1 < cols_s1);
	assign side_in.corner_a   = base_s1 + IW'(col_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < S; k++)
				vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= vld_s1;
			for (int k = 1; k < S; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_in;
			for (int k = 1; k < S; k++)
				side_s[k] <= side_s[k-1];
		end
	end

	// Output stage: centering, facing turn, UV and corner indices.
	logic [PW-1:0] px_c, py_c, px_f, py_f, pz_f;
	logic [1:0]    axis_f;
	logic [IW-1:0] a_f, b_f, c_f, d_f;
	pgm_pkg::side_t side_l;

	assign side_l = side_s[S-1];
	assign px_c   = PW'(qx) - PW'(width_q[SW-1:1]);
	assign py_c   = PW'(qy) - PW'(height_q[SW-1:1]);

	always_comb begin
		px_f   = px_c;
		py_f   = py_c;
		pz_f   = '0;
		axis_f = pgm_pkg::AXIS_Z;
		if (dir_q == pgm_pkg::DIR_X) begin
			pz_f   = PW'(0) - px_c;
			px_f   = '0;
			axis_f = pgm_pkg::AXIS_X;
		end else if (dir_q == pgm_pkg::DIR_Y) begin
			pz_f   = PW'(0) - py_c;
			py_f   = '0;
			axis_f = pgm_pkg::AXIS_Y;
		end
		if (!nrm_en_q)
			axis_f = pgm_pkg::AXIS_NONE;
		a_f = '0;
		b_f = '0;
		c_f = '0;
		d_f = '0;
		if (side_l.quad_valid) begin
			a_f = side_l.corner_a;
			b_f = side_l.corner_a + IW'(1);
			c_f = side_l.corner_a + IW'(cols_c) + IW'(1);
			d_f = side_l.corner_a + IW'(cols_c) + IW'(2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= vld_s[S-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_x       <= px_f;
			pos_y       <= py_f;
			pos_z       <= pz_f;
			tex_u       <= uv_en_q ? qu[pgm_pkg::UV_W-1:0] : '0;
			tex_v       <= uv_en_q ? qv[pgm_pkg::UV_W-1:0] : '0;
			normal_axis <= axis_f;
			quad_valid  <= side_l.quad_valid;
			corner_a    <= a_f;
			corner_b    <= b_f;
			corner_c    <= c_f;
			corner_d    <= d_f;
		end
	end

endmodule

/* src/pgm_checker.sv */
module pgm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [pgm_pkg::POS_W-1:0] pos_x,
	input logic                             quad_valid,
	input logic [pgm_pkg::IDX_W-1:0]        corner_a,
	input logic [pgm_pkg::IDX_W-1:0]        corner_b,
	input logic [pgm_pkg::IDX_W-1:0]        corner_c,
	input logic [pgm_pkg::IDX_W-1:0]        corner_d
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(corner_a))
		else $error("stalled output transaction changed");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while the pipeline is stalled");

	a_no_quad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !quad_valid |-> corner_a == '0 && corner_d == '0)
		else $error("corner indices set without a quad");

	a_quad_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && quad_valid |->
			corner_b == corner_a + 21'd1 && corner_d == corner_c + 21'd1)
		else $error("quad corners inconsistent");

endmodule

bind plane_grid_mesh_generator_top pgm_checker u_pgm_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .pos_x(pos_x),
	.quad_valid(quad_valid), .corner_a(corner_a), .corner_b(corner_b),
	.corner_c(corner_c), .corner_d(corner_d)
);

/* sim/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD    = 20;
	localparam int MAX_CYCLE = 1000000;
	localparam int DRAIN     = 40;
	localparam int SW        = pgm_pkg::SIZE_W;
	localparam int GW        = pgm_pkg::GRID_W;
	localparam int PW        = pgm_pkg::POS_W;
	localparam int UW        = pgm_pkg::UV_W;
	localparam int IW        = pgm_pkg::IDX_W;

	typedef struct packed {
		logic [PW-1:0] pos_x;
		logic [PW-1:0] pos_y;
		logic [PW-1:0] pos_z;
		logic [UW-1:0] tex_u;
		logic [UW-1:0] tex_v;
		logic [1:0]    normal_axis;
		logic          quad_valid;
		logic [IW-1:0] corner_a;
		logic [IW-1:0] corner_b;
		logic [IW-1:0] corner_c;
		logic [IW-1:0] corner_d;
	} vertex_t;

	class vertex_scoreboard;
		logic [SW-1:0] width, height;
		logic [GW-1:0] cols_reg, rows_reg;
		logic [1:0]    dir;
		logic          uv_on, normal_on;
		vertex_t       pending_q[$];
		int            errors;

		function void reset_regs();
			width = 24'd65536;
			height = 24'd65536;
			cols_reg = 11'd1;
			rows_reg = 11'd1;
			dir = pgm_pkg::DIR_Z;
			uv_on = 1'b1;
			normal_on = 1'b1;
		endfunction

		function void set_reg(pgm_pkg::reg_idx_t idx, logic [SW-1:0] d);
			case (idx)
				pgm_pkg::REG_PLANE_WIDTH:  width = d;
				pgm_pkg::REG_PLANE_HEIGHT: height = d;
				pgm_pkg::REG_GRID_COLS:    cols_reg = d[GW-1:0];
				pgm_pkg::REG_GRID_ROWS:    rows_reg = d[GW-1:0];
				pgm_pkg::REG_PLANE_DIR:    dir = d[1:0];
				pgm_pkg::REG_UV_ENABLE:    uv_on = d[0];
				pgm_pkg::REG_NORMAL_EN:    normal_on = d[0];
				default:                   ;
			endcase
		endfunction

		function longint grid_size(logic [GW-1:0] n);
			if (n == 0)
				return 1;
			if (n > pgm_pkg::GRID_MAX)
				return pgm_pkg::GRID_MAX;
			return longint'(n);
		endfunction

		// Computes the vertex for one grid point and queues it.
		function void note_point(logic [GW-1:0] r_in, logic [GW-1:0] c_in);
			longint  cols, rows, r, c, px, py, pz, a;
			vertex_t v;
			cols = grid_size(cols_reg);
			rows = grid_size(rows_reg);
			r = (r_in > rows) ? rows : longint'(r_in);
			c = (c_in > cols) ? cols : longint'(c_in);
			px = (longint'(width) * c) / cols - longint'(width >> 1);
			py = (longint'(height) * r) / rows - longint'(height >> 1);
			pz = 0;
			v.normal_axis = pgm_pkg::AXIS_Z;
			if (dir == pgm_pkg::DIR_X) begin
				pz = -px;
				px = 0;
				v.normal_axis = pgm_pkg::AXIS_X;
			end else if (dir == pgm_pkg::DIR_Y) begin
				pz = -py;
				py = 0;
				v.normal_axis = pgm_pkg::AXIS_Y;
			end
			if (!normal_on)
				v.normal_axis = pgm_pkg::AXIS_NONE;
			v.pos_x = px[PW-1:0];
			v.pos_y = py[PW-1:0];
			v.pos_z = pz[PW-1:0];
			v.tex_u = uv_on ? UW'((c << pgm_pkg::FRAC_BITS) / cols) : '0;
			v.tex_v = uv_on ? UW'((r << pgm_pkg::FRAC_BITS) / rows) : '0;
			v.quad_valid = (r < rows) && (c < cols);
			a = r * (cols + 1) + c;
			v.corner_a = v.quad_valid ? IW'(a) : '0;
			v.corner_b = v.quad_valid ? IW'(a + 1) : '0;
			v.corner_c = v.quad_valid ? IW'(a + cols + 1) : '0;
			v.corner_d = v.quad_valid ? IW'(a + cols + 2) : '0;
			pending_q.insert(pending_q.size(), v);
		endfunction

		task report(string what, longint got, longint want);
			$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
			errors++;
		endtask

		task check_vertex(vertex_t got);
			vertex_t w;
			if (pending_q.size() == 0) begin
				report("unexpected vertex transaction", 1, 0);
				return;
			end
			w = pending_q.pop_front();
			if (got.pos_x !== w.pos_x) report("pos_x", got.pos_x, w.pos_x);
			if (got.pos_y !== w.pos_y) report("pos_y", got.pos_y, w.pos_y);
			if (got.pos_z !== w.pos_z) report("pos_z", got.pos_z, w.pos_z);
			if (got.tex_u !== w.tex_u) report("tex_u", got.tex_u, w.tex_u);
			if (got.tex_v !== w.tex_v) report("tex_v", got.tex_v, w.tex_v);
			if (got.normal_axis !== w.normal_axis)
				report("normal_axis", got.normal_axis, w.normal_axis);
			if (got.quad_valid !== w.quad_valid)
				report("quad_valid", got.quad_valid, w.quad_valid);
			if (got.corner_a !== w.corner_a) report("corner_a", got.corner_a, w.corner_a);
			if (got.corner_b !== w.corner_b) report("corner_b", got.corner_b, w.corner_b);
			if (got.corner_c !== w.corner_c) report("corner_c", got.corner_c, w.corner_c);
			if (got.corner_d !== w.corner_d) report("corner_d", got.corner_d, w.corner_d);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	pgm_pkg::reg_idx_t cfg_index = pgm_pkg::REG_PLANE_WIDTH;
	logic [SW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [GW-1:0] grid_row = '0, grid_col = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [PW-1:0] pos_x, pos_y, pos_z;
	logic [UW-1:0] tex_u, tex_v;
	logic [1:0] normal_axis;
	logic quad_valid;
	logic [IW-1:0] corner_a, corner_b, corner_c, corner_d;

	vertex_scoreboard sb = new();
	int cycle_count = 0;
	bit hold_request = 0;

	plane_grid_mesh_generator_top DUT (.*);

	always #(PERIOD/2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLE) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Inputs move on the falling edge, so the rising edge sees settled values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_point(grid_row, grid_col);
			if (out_valid && out_ready)
				sb.check_vertex({pos_x, pos_y, pos_z, tex_u, tex_v, normal_axis,
					quad_valid, corner_a, corner_b, corner_c, corner_d});
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Receiver: random back-pressure, or one long hold-off when asked for.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready = 1'b0;
				repeat (300) @(negedge clk);
				hold_request = 0;
			end else begin
				n = gap_len();
				if (n > 0) begin
					out_ready = 1'b0;
					repeat (n) @(negedge clk);
				end
				out_ready = 1'b1;
				repeat ($urandom_range(0, 20)) @(negedge clk);
			end
		end
	end

	task automatic write_reg(pgm_pkg::reg_idx_t idx, logic [SW-1:0] d);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_point(logic [GW-1:0] r, logic [GW-1:0] c, bit no_gap);
		in_valid = 1'b1;
		grid_row = r;
		grid_col = c;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
		if (!no_gap)
			repeat (gap_len()) @(negedge clk);
	endtask

	task automatic wait_idle();
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic set_all(logic [SW-1:0] w, logic [SW-1:0] h,
			logic [GW-1:0] c, logic [GW-1:0] r, logic [1:0] d, bit uv, bit nrm);
		wait_idle();
		write_reg(pgm_pkg::REG_PLANE_WIDTH, w);
		write_reg(pgm_pkg::REG_PLANE_HEIGHT, h);
		write_reg(pgm_pkg::REG_GRID_COLS, SW'(c));
		write_reg(pgm_pkg::REG_GRID_ROWS, SW'(r));
		write_reg(pgm_pkg::REG_PLANE_DIR, SW'(d));
		write_reg(pgm_pkg::REG_UV_ENABLE, SW'(uv));
		write_reg(pgm_pkg::REG_NORMAL_EN, SW'(nrm));
	endtask

	// Points mostly inside the grid, with the edge and clamped cases mixed in.
	task automatic random_points(int count, bit no_gap);
		int cols, rows, k;
		logic [GW-1:0] r, c;
		cols = int'(sb.grid_size(sb.cols_reg));
		rows = int'(sb.grid_size(sb.rows_reg));
		repeat (count) begin
			k = $urandom_range(0, 9);
			r = (k < 7) ? GW'($urandom_range(0, rows)) : GW'($urandom);
			c = (k < 7) ? GW'($urandom_range(0, cols)) : GW'($urandom);
			if (k == 9) begin
				r = GW'(rows);
				c = GW'(cols);
			end
			send_point(r, c, no_gap);
		end
	endtask

	initial begin
		sb.reset_regs();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: corners, the far edge and clamped indexes.
		send_point(11'd0, 11'd0, 1'b0);
		send_point(11'd0, 11'd1, 1'b0);
		send_point(11'd1, 11'd0, 1'b0);
		send_point(11'd1, 11'd1, 1'b0);
		send_point(11'h7FF, 11'h7FF, 1'b0);
		send_point(11'd1024, 11'd3, 1'b0);

		set_all(24'hFFFFFF, 24'd1, 11'd1024, 11'd1024, pgm_pkg::DIR_X, 1'b1, 1'b1);
		send_point(11'd0, 11'd0, 1'b0);
		send_point(11'd1023, 11'd1023, 1'b0);
		send_point(11'd1024, 11'd1024, 1'b0);
		send_point(11'd512, 11'd1, 1'b0);
		send_point(11'h7FF, 11'd0, 1'b0);

		// Zero-sized plane, zero grid count, oversized grid count.
		set_all(24'd0, 24'd0, 11'd0, 11'h7FF, pgm_pkg::DIR_Y, 1'b0, 1'b0);
		send_point(11'd0, 11'd0, 1'b0);
		send_point(11'd1, 11'd1, 1'b0);
		send_point(11'd1023, 11'd0, 1'b0);
		send_point(11'd1024, 11'd2, 1'b0);
		send_point(11'h555, 11'h2AA, 1'b0);

		// Unused direction code behaves as Z.
		set_all(24'd300000, 24'd777777, 11'd7, 11'd3, 2'd3, 1'b1, 1'b1);
		send_point(11'd0, 11'd0, 1'b0);
		send_point(11'd2, 11'd6, 1'b0);
		send_point(11'd3, 11'd7, 1'b0);
		send_point(11'd9, 11'd9, 1'b0);

		for (int phase = 0; phase < 9; phase++) begin
			set_all(SW'($urandom), SW'($urandom),
				(phase % 3 == 2) ? GW'($urandom) : GW'($urandom_range(1, 16)),
				(phase % 3 == 1) ? GW'($urandom) : GW'($urandom_range(1, 16)),
				2'($urandom), 1'($urandom), 1'($urandom));
			if (phase == 3) begin
				// Long output stall while the input keeps offering points.
				hold_request = 1;
				random_points(80, 1'b1);
			end
			random_points(100, 1'b0);
			// Pause until the pipeline is empty, then carry on with the same settings.
			while (sb.pending_q.size() != 0) @(negedge clk);
			random_points(100, 1'b0);
		end

		set_all(24'hFFFFFF, 24'hFFFFFF, 11'd1, 11'd1024, pgm_pkg::DIR_Y, 1'b1, 1'b0);
		random_points(60, 1'b0);

		wait_idle();
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

/* plane_grid_mesh_generator_top.f */
src/pgm_pkg.sv
src/pgm_div.sv
src/plane_grid_mesh_generator_top.sv
src/pgm_checker.sv
sim/testbench.sv
